// ----- sv/magnetometer_heading_atan2_unit_assert.svh -----
// assertion macros for the magnetometer heading unit
// expects clk and arst_n in the scope of the including module
`ifndef MAGNETOMETER_HEADING_ATAN2_UNIT_ASSERT_SVH
`define MAGNETOMETER_HEADING_ATAN2_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define HDG_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HDG_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/hdg_pkg.sv -----
// shared constants, types and the arctangent table of the heading unit
// no dependencies
`default_nettype none

package hdg_pkg;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned TABLE_LEN    = 24;
	localparam int unsigned STEPS_USED   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int unsigned SHIFT_W      = $clog2(TABLE_LEN);

	localparam int unsigned MAG_W     = 16;
	localparam int unsigned VEC_SHIFT = 20;
	// vector grows by the cordic gain and the diagonal, three guard bits cover it
	localparam int unsigned VEC_W     = MAG_W + VEC_SHIFT + 3;
	localparam int unsigned ANG_W     = 25;
	localparam int unsigned TH_W      = 24;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned DEG_W     = TH_W - FRAC_W;

	localparam logic [TH_W-1:0]  DEG45_Q16   = TH_W'(2949120);
	localparam logic [TH_W-1:0]  DEG90_Q16   = TH_W'(5898240);
	localparam logic [TH_W-1:0]  DEG180_Q16  = TH_W'(11796480);
	localparam logic [DEG_W-1:0] DEG_NEG_MAX = DEG_W'(179);

	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic ax_zero;
		logic ay_zero;
		logic same_mag;
		logic x_major;
	} hdg_flags_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] x_value;
		logic signed [MAG_W-1:0] y_value;
		logic signed [MAG_W-1:0] z_value;
		hdg_flags_t              flags;
	} hdg_carry_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ANG_W-1:0] ang;
	} hdg_vec_t;

	// atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
	function automatic logic signed [ANG_W-1:0] atan_q16(input logic [SHIFT_W-1:0] idx);
		logic signed [ANG_W-1:0] r;
		case (idx)
			0:       r = ANG_W'(2949120);
			1:       r = ANG_W'(1740967);
			2:       r = ANG_W'(919879);
			3:       r = ANG_W'(466945);
			4:       r = ANG_W'(234379);
			5:       r = ANG_W'(117304);
			6:       r = ANG_W'(58666);
			7:       r = ANG_W'(29335);
			8:       r = ANG_W'(14668);
			9:       r = ANG_W'(7334);
			10:      r = ANG_W'(3667);
			11:      r = ANG_W'(1833);
			12:      r = ANG_W'(917);
			13:      r = ANG_W'(458);
			14:      r = ANG_W'(229);
			15:      r = ANG_W'(115);
			16:      r = ANG_W'(57);
			17:      r = ANG_W'(29);
			18:      r = ANG_W'(14);
			19:      r = ANG_W'(7);
			20:      r = ANG_W'(4);
			21:      r = ANG_W'(2);
			22:      r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- sv/hdg_in_if.sv -----
// sample channel: six raw bytes with valid/ready
// no dependencies
`default_nettype none

interface hdg_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] x_high_byte;
	logic [7:0] x_low_byte;
	logic [7:0] z_high_byte;
	logic [7:0] z_low_byte;
	logic [7:0] y_high_byte;
	logic [7:0] y_low_byte;

	modport source (
		output valid, x_high_byte, x_low_byte, z_high_byte, z_low_byte,
			y_high_byte, y_low_byte,
		input  ready
	);
	modport sink (
		input  valid, x_high_byte, x_low_byte, z_high_byte, z_low_byte,
			y_high_byte, y_low_byte,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/hdg_out_if.sv -----
// result channel: axis values and heading with valid/ready
// no dependencies
`default_nettype none

interface hdg_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic signed [15:0] z_value;
	logic signed [8:0]  heading_degrees;

	modport source (
		output valid, x_value, y_value, z_value, heading_degrees,
		input  ready
	);
	modport sink (
		input  valid, x_value, y_value, z_value, heading_degrees,
		output ready
	);
endinterface

`default_nettype wire

// ----- sv/hdg_prep.sv -----
// front stage: byte join, magnitudes, octant selection, cordic seed
// depends on hdg_pkg
`default_nettype none

module hdg_prep (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [7:0]       x_high_byte,
	input  wire logic [7:0]       x_low_byte,
	input  wire logic [7:0]       z_high_byte,
	input  wire logic [7:0]       z_low_byte,
	input  wire logic [7:0]       y_high_byte,
	input  wire logic [7:0]       y_low_byte,
	output logic                  valid_s1,
	output hdg_pkg::hdg_carry_t   carry_s1,
	output hdg_pkg::hdg_vec_t     vec_s1
);

	localparam int unsigned PAD_W = hdg_pkg::VEC_W - hdg_pkg::MAG_W - hdg_pkg::VEC_SHIFT;

	logic signed [hdg_pkg::MAG_W-1:0] x_val, y_val, z_val;
	logic [hdg_pkg::MAG_W-1:0]        ax, ay, mag_a, mag_b;
	hdg_pkg::hdg_carry_t              carry_d;
	hdg_pkg::hdg_vec_t                vec_d;

	assign x_val = {x_high_byte, x_low_byte};
	assign y_val = {y_high_byte, y_low_byte};
	assign z_val = {z_high_byte, z_low_byte};

	// unsigned magnitude, -32768 maps to 32768
	assign ax = x_val[hdg_pkg::MAG_W-1] ? (~x_val + 1'b1) : x_val;
	assign ay = y_val[hdg_pkg::MAG_W-1] ? (~y_val + 1'b1) : y_val;

	always_comb begin
		carry_d.x_value        = x_val;
		carry_d.y_value        = y_val;
		carry_d.z_value        = z_val;
		carry_d.flags.x_neg    = x_val[hdg_pkg::MAG_W-1];
		carry_d.flags.y_neg    = y_val[hdg_pkg::MAG_W-1];
		carry_d.flags.ax_zero  = (ax == '0);
		carry_d.flags.ay_zero  = (ay == '0);
		carry_d.flags.same_mag = (ax == ay);
		carry_d.flags.x_major  = (ax > ay);
		mag_a = carry_d.flags.x_major ? ax : ay;
		mag_b = carry_d.flags.x_major ? ay : ax;
		vec_d.vx  = {{PAD_W{1'b0}}, mag_a, {hdg_pkg::VEC_SHIFT{1'b0}}};
		vec_d.vy  = {{PAD_W{1'b0}}, mag_b, {hdg_pkg::VEC_SHIFT{1'b0}}};
		vec_d.ang = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			carry_s1 <= carry_d;
			vec_s1   <= vec_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/hdg_cordic_step.sv -----
// one vectoring iteration of the cordic pipeline with its stage register
// depends on hdg_pkg
`default_nettype none

module hdg_cordic_step (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [hdg_pkg::SHIFT_W-1:0] step_idx,
	input  wire logic                        en,
	input  wire logic                        valid_s1,
	input  wire hdg_pkg::hdg_carry_t         carry_s1,
	input  wire hdg_pkg::hdg_vec_t           vec_s1,
	output logic                             valid_s2,
	output hdg_pkg::hdg_carry_t              carry_s2,
	output hdg_pkg::hdg_vec_t                vec_s2
);

	logic signed [hdg_pkg::VEC_W-1:0] vx, vy, dx, dy;
	logic signed [hdg_pkg::ANG_W-1:0] ang, step_ang;
	hdg_pkg::hdg_vec_t                vec_d;

	assign vx       = vec_s1.vx;
	assign vy       = vec_s1.vy;
	assign ang      = vec_s1.ang;
	assign dx       = vy >>> step_idx;
	assign dy       = vx >>> step_idx;
	assign step_ang = hdg_pkg::atan_q16(step_idx);

	// rotate toward the x axis
	always_comb begin
		if (!vy[hdg_pkg::VEC_W-1]) begin
			vec_d.vx  = vx + dx;
			vec_d.vy  = vy - dy;
			vec_d.ang = ang + step_ang;
		end else begin
			vec_d.vx  = vx - dx;
			vec_d.vy  = vy + dy;
			vec_d.ang = ang - step_ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			carry_s2 <= carry_s1;
			vec_s2   <= vec_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/hdg_finish.sv -----
// back end: octant clamp and unfold, then degrees and sign, output register
// depends on hdg_pkg
`default_nettype none

module hdg_finish (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        valid_s1,
	input  wire hdg_pkg::hdg_carry_t         carry_s1,
	input  wire logic signed [hdg_pkg::ANG_W-1:0] ang_s1,
	input  wire logic                        out_ready,
	output logic                             in_ready,
	output logic                             valid_s3,
	output logic signed [hdg_pkg::MAG_W-1:0] x_value,
	output logic signed [hdg_pkg::MAG_W-1:0] y_value,
	output logic signed [hdg_pkg::MAG_W-1:0] z_value,
	output logic signed [8:0]                heading_degrees
);

	logic                        en_a, en_b;
	logic                        valid_s2;
	hdg_pkg::hdg_carry_t         carry_s2;
	logic [hdg_pkg::TH_W-1:0]    th_s2;
	logic [hdg_pkg::TH_W-1:0]    oct, th_d, th_full;
	logic [hdg_pkg::DEG_W-1:0]   mag_deg, cap_deg;
	logic signed [8:0]           heading_d;

	assign en_b     = !valid_s3 || out_ready;
	assign en_a     = !valid_s2 || en_b;
	assign in_ready = en_a;

	// first octant clamp, then unfold into the first quadrant
	always_comb begin
		if (ang_s1[hdg_pkg::ANG_W-1]) begin
			oct = '0;
		end else if (ang_s1 > $signed({1'b0, hdg_pkg::DEG45_Q16})) begin
			oct = hdg_pkg::DEG45_Q16;
		end else begin
			oct = ang_s1[hdg_pkg::TH_W-1:0];
		end
		if (carry_s1.flags.ay_zero) begin
			th_d = '0;
		end else if (carry_s1.flags.ax_zero) begin
			th_d = hdg_pkg::DEG90_Q16;
		end else if (carry_s1.flags.same_mag) begin
			th_d = hdg_pkg::DEG45_Q16;
		end else if (carry_s1.flags.x_major) begin
			th_d = oct;
		end else begin
			th_d = hdg_pkg::DEG90_Q16 - oct;
		end
	end

	// left half plane, truncation to degrees, sign of y
	always_comb begin
		th_full = carry_s2.flags.x_neg ? (hdg_pkg::DEG180_Q16 - th_s2) : th_s2;
		mag_deg = th_full[hdg_pkg::TH_W-1:hdg_pkg::FRAC_W];
		cap_deg = (mag_deg > hdg_pkg::DEG_NEG_MAX) ? hdg_pkg::DEG_NEG_MAX : mag_deg;
		if (carry_s2.flags.y_neg) begin
			heading_d = -$signed({1'b0, cap_deg});
		end else begin
			heading_d = $signed({1'b0, mag_deg});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_a) begin
				valid_s2 <= valid_s1;
			end
			if (en_b) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_a && valid_s1) begin
			carry_s2 <= carry_s1;
			th_s2    <= th_d;
		end
		if (en_b && valid_s2) begin
			x_value         <= carry_s2.x_value;
			y_value         <= carry_s2.y_value;
			z_value         <= carry_s2.z_value;
			heading_degrees <= heading_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/magnetometer_heading_atan2_unit.sv -----
// magnetometer heading unit top level: front stage, cordic pipeline, back end
// depends on hdg_pkg, hdg_in_if, hdg_out_if, hdg_prep, hdg_cordic_step, hdg_finish
// usage:
//   sample carries one reading per beat as six raw bytes (x, z, y, high first);
//   result returns the signed x, y, z values and the heading atan2(y, x) in
//   whole degrees, truncated toward zero, range -179 to 180, zero when x = y = 0
// pipeline: the accepting edge loads the front stage (byte join and octant
//   fold), then one stage per cordic iteration, then two for the unfold and
//   degree conversion, the last of which is the output register
// throughput: one beat per cycle while result.ready stays high, and every
//   stage holds an independent sample
// stalls: each stage loads when it is empty or its successor moves, so a
//   held result.ready freezes only the occupied stages and bubbles close up;
//   sample.ready stays high while the front stage has room
// reset: arst_n clears every stage valid bit at once; data registers keep
//   whatever they held and are never shown until refilled
`default_nettype none

module magnetometer_heading_atan2_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	hdg_in_if.sink    sample,
	hdg_out_if.source result
);

	`include "magnetometer_heading_atan2_unit_assert.svh"

	localparam int unsigned N = hdg_pkg::STEPS_USED;

	// index 0 is the front stage output, index k the output of iteration k
	logic                stage_vld   [N+1];
	logic                stage_en    [N+1];
	hdg_pkg::hdg_carry_t stage_carry [N+1];
	hdg_pkg::hdg_vec_t   stage_vec   [N+1];
	logic                fin_ready;

	hdg_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (stage_en[0]),
		.in_valid    (sample.valid),
		.x_high_byte (sample.x_high_byte),
		.x_low_byte  (sample.x_low_byte),
		.z_high_byte (sample.z_high_byte),
		.z_low_byte  (sample.z_low_byte),
		.y_high_byte (sample.y_high_byte),
		.y_low_byte  (sample.y_low_byte),
		.valid_s1    (stage_vld[0]),
		.carry_s1    (stage_carry[0]),
		.vec_s1      (stage_vec[0])
	);

	assign sample.ready = stage_en[0];

	// one shared-nothing iteration per stage, shift and table entry fixed per slot
	for (genvar k = 1; k <= N; k++) begin : g_step
		hdg_cordic_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.step_idx (hdg_pkg::SHIFT_W'(k - 1)),
			.en       (stage_en[k]),
			.valid_s1 (stage_vld[k-1]),
			.carry_s1 (stage_carry[k-1]),
			.vec_s1   (stage_vec[k-1]),
			.valid_s2 (stage_vld[k]),
			.carry_s2 (stage_carry[k]),
			.vec_s2   (stage_vec[k])
		);
	end

	// load enables ripple back from the output register
	for (genvar k = 0; k < N; k++) begin : g_en
		assign stage_en[k] = !stage_vld[k] || stage_en[k+1];
	end
	assign stage_en[N] = !stage_vld[N] || fin_ready;

	hdg_finish u_finish (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (stage_vld[N]),
		.carry_s1        (stage_carry[N]),
		.ang_s1          (stage_vec[N].ang),
		.out_ready       (result.ready),
		.in_ready        (fin_ready),
		.valid_s3        (result.valid),
		.x_value         (result.x_value),
		.y_value         (result.y_value),
		.z_value         (result.z_value),
		.heading_degrees (result.heading_degrees)
	);

	// heading stays in its documented range
	`HDG_IMPLIES(a_heading_range, result.valid,
		(result.heading_degrees >= -9'sd179) && (result.heading_degrees <= 9'sd180),
		"heading out of range")
	// positive x axis and origin give zero
	`HDG_IMPLIES(a_pos_x_axis, result.valid && (result.y_value == 16'sd0) && !result.x_value[15],
		result.heading_degrees == 9'sd0, "heading not zero on positive x axis")
	// positive y axis gives a right angle
	`HDG_IMPLIES(a_pos_y_axis,
		result.valid && (result.x_value == 16'sd0) && (result.y_value > 16'sd0),
		result.heading_degrees == 9'sd90, "heading not 90 on positive y axis")
	// negative y never gives a positive heading, tiny angles truncate to zero
	`HDG_IMPLIES(a_heading_sign, result.valid && result.y_value[15],
		result.heading_degrees <= 9'sd0, "heading positive for negative y")
	// an empty front stage always takes a beat
	`HDG_IMPLIES(a_front_ready, !stage_vld[0], sample.ready, "front stage empty but not ready")

endmodule

`default_nettype wire

// ----- tb/magnetometer_heading_atan2_unit_tb.sv -----
// self-checking testbench for the magnetometer heading unit
// predicts axis values and cordic heading per sample and checks every result beat
// depends on hdg_pkg, hdg_in_if, hdg_out_if and magnetometer_heading_atan2_unit
`timescale 1ns / 1ps

module magnetometer_heading_atan2_unit_tb;

	localparam int CLK_HALF_NS  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int PIPE_LATENCY = 2 + hdg_pkg::STEPS_USED;
	// the timeout allows several times the slowest legal run
	localparam longint TIMEOUT_NS = 5_000_000;

	// atan(2^-i) in degrees with 16 fractional bits
	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};
	localparam longint Q16_45  = 2949120;
	localparam longint Q16_90  = 5898240;
	localparam longint Q16_180 = 11796480;

	typedef struct packed {
		logic [7:0] x_hi;
		logic [7:0] x_lo;
		logic [7:0] z_hi;
		logic [7:0] z_lo;
		logic [7:0] y_hi;
		logic [7:0] y_lo;
	} raw_sample_t;

	typedef struct packed {
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
		logic signed [15:0] z_value;
		logic signed [8:0]  heading;
	} reading_t;

	// shapes of random samples
	typedef enum int {
		KIND_RAW_BYTES,
		KIND_SMALL,
		KIND_DIAGONAL,
		KIND_ON_AXIS,
		KIND_NEG_X_AXIS,
		KIND_EXTREME
	} sample_kind_e;

	logic clk;
	logic arst_n;

	hdg_in_if  sample_ch ();
	hdg_out_if result_ch ();

	magnetometer_heading_atan2_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	// readings predicted at the accepting edge, oldest first
	reading_t pending_readings [$];
	int       mismatch_count;

	// idle controls, set by the tests in the main process
	int source_gap_max;
	int sink_stall_max;
	int sink_hold_cycles;

	always begin
		clk = 1'b1;
		#(CLK_HALF_NS);
		clk = 1'b0;
		#(CLK_HALF_NS);
	end

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// vectoring cordic in the first octant, big >= little > 0, result in degrees q16
	function automatic longint octant_angle(input longint big, input longint little);
		longint vx, vy, ang, dx, dy;
		vx  = big <<< 20;
		vy  = little <<< 20;
		ang = 0;
		for (int i = 0; i < hdg_pkg::STEPS_USED; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy >= 0) begin
				vx  = vx + dx;
				vy  = vy - dy;
				ang = ang + ATAN_DEG_Q16[i];
			end else begin
				vx  = vx - dx;
				vy  = vy + dy;
				ang = ang - ATAN_DEG_Q16[i];
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > Q16_45)
			ang = Q16_45;
		return ang;
	endfunction

	// heading in whole degrees, folded out of the first octant by symmetry
	function automatic logic signed [8:0] heading_degrees_of(input logic signed [15:0] xv,
			input logic signed [15:0] yv);
		longint ax, ay, th;
		int     deg;
		ax = (xv < 0) ? -longint'(xv) : longint'(xv);
		ay = (yv < 0) ? -longint'(yv) : longint'(yv);
		if (ax == 0 && ay == 0)
			return '0;
		if (ay == 0)
			th = 0;
		else if (ax == 0)
			th = Q16_90;
		else if (ax == ay)
			th = Q16_45;
		else if (ax > ay)
			th = octant_angle(ax, ay);
		else
			th = Q16_90 - octant_angle(ay, ax);
		if (xv < 0)
			th = Q16_180 - th;
		deg = int'(th >>> 16);
		// negative y never reaches -180
		if (yv < 0) begin
			if (deg > 179)
				deg = 179;
			deg = -deg;
		end
		return 9'(deg);
	endfunction

	function automatic reading_t predict_reading(input raw_sample_t s);
		reading_t r;
		r.x_value = $signed({s.x_hi, s.x_lo});
		r.y_value = $signed({s.y_hi, s.y_lo});
		r.z_value = $signed({s.z_hi, s.z_lo});
		r.heading = heading_degrees_of(r.x_value, r.y_value);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------

	function automatic int clamp16(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic raw_sample_t pack_axes(input int xv, input int yv, input int zv);
		raw_sample_t s;
		logic [15:0] xb, yb, zb;
		xb = 16'(xv);
		yb = 16'(yv);
		zb = 16'(zv);
		s.x_hi = xb[15:8];
		s.x_lo = xb[7:0];
		s.y_hi = yb[15:8];
		s.y_lo = yb[7:0];
		s.z_hi = zb[15:8];
		s.z_lo = zb[7:0];
		return s;
	endfunction

	function automatic int random_sign(input int v);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic raw_sample_t random_sample();
		sample_kind_e kind;
		raw_sample_t  s;
		int           m, xv, yv, zv;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: kind = KIND_RAW_BYTES;
			4:          kind = KIND_SMALL;
			5, 6:       kind = KIND_DIAGONAL;
			7:          kind = KIND_ON_AXIS;
			8:          kind = KIND_NEG_X_AXIS;
			default:    kind = KIND_EXTREME;
		endcase
		zv = clamp16(int'($urandom_range(0, 65535)) - 32768);
		case (kind)
			KIND_RAW_BYTES: begin
				s = raw_sample_t'({$urandom(), $urandom()});
				return s;
			end
			KIND_SMALL: begin
				xv = int'($urandom_range(0, 8)) - 4;
				yv = int'($urandom_range(0, 8)) - 4;
			end
			KIND_DIAGONAL: begin
				// magnitudes equal or one apart, all four quadrants
				m  = $urandom_range(1, 32767);
				xv = random_sign(m);
				yv = clamp16(random_sign(m + int'($urandom_range(0, 2)) - 1));
			end
			KIND_ON_AXIS: begin
				m = $urandom_range(0, 32768);
				if ($urandom_range(0, 1)) begin
					xv = clamp16(random_sign(m));
					yv = 0;
				end else begin
					xv = 0;
					yv = clamp16(random_sign(m));
				end
			end
			KIND_NEG_X_AXIS: begin
				// just below or above the negative x axis, where the cap matters
				xv = -int'($urandom_range(1000, 32768));
				yv = random_sign($urandom_range(0, 200));
			end
			default: begin
				xv = $urandom_range(0, 1) ? 32767 : -32768;
				yv = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? 32767 : -32768);
				zv = $urandom_range(0, 1) ? 32767 : -32768;
			end
		endcase
		return pack_axes(xv, yv, zv);
	endfunction

	// one sample beat; called at a rising edge, returns at the accepting edge
	// valid stays high so a following beat with no gap goes out back to back
	task automatic send_sample(input raw_sample_t s);
		int gap;
		gap = $urandom_range(0, source_gap_max);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.x_high_byte <= s.x_hi;
		sample_ch.x_low_byte  <= s.x_lo;
		sample_ch.z_high_byte <= s.z_hi;
		sample_ch.z_low_byte  <= s.z_lo;
		sample_ch.y_high_byte <= s.y_hi;
		sample_ch.y_low_byte  <= s.y_lo;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pending_readings.push_back(predict_reading(s));
	endtask

	task automatic send_random_samples(input int count);
		repeat (count)
			send_sample(random_sample());
	endtask

	// lower valid and wait until every predicted reading has come back
	task automatic wait_for_results();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// zero vector, both axes at their extremes, exact diagonals, the -180 cap
	task automatic test_special_headings();
		source_gap_max = 3;
		sink_stall_max = 3;
		send_sample(pack_axes(0, 0, 0));
		send_sample(pack_axes(32767, 0, 32767));
		send_sample(pack_axes(-32768, 0, -32768));
		send_sample(pack_axes(-1, 0, 1));
		send_sample(pack_axes(0, 32767, 0));
		send_sample(pack_axes(0, -32768, 0));
		send_sample(pack_axes(0, 1, -1));
		send_sample(pack_axes(100, 100, 5));
		send_sample(pack_axes(-100, 100, 5));
		send_sample(pack_axes(-100, -100, 5));
		send_sample(pack_axes(100, -100, 5));
		send_sample(pack_axes(-32768, -32768, 0));
		send_sample(pack_axes(32767, 32767, 0));
		send_sample(pack_axes(-32768, -1, 0));
		send_sample(pack_axes(-32768, 1, 0));
		send_sample(pack_axes(-32767, -32768, 0));
		send_sample(pack_axes(32767, -1, 0));
		send_sample(pack_axes(1, 32767, 0));
		send_sample(pack_axes(3, 4, 0));
		// raw bytes: all ones, then extreme and near-extreme axis values
		send_sample(raw_sample_t'({6{8'hff}}));
		send_sample(raw_sample_t'({8'h80, 8'h00, 8'h7f, 8'hff, 8'h80, 8'h01}));
		send_sample(raw_sample_t'({8'h00, 8'h01, 8'h00, 8'h00, 8'h7f, 8'hff}));
		wait_for_results();
	endtask

	// no idling on either side, the pipeline runs at full rate
	task automatic test_back_to_back_stream();
		source_gap_max = 0;
		sink_stall_max = 0;
		send_random_samples(300);
		wait_for_results();
	endtask

	// both sides idle per beat, so gaps land on every pipeline stage
	task automatic test_random_idle_stream();
		source_gap_max = 18;
		sink_stall_max = 18;
		send_random_samples(700);
		wait_for_results();
	endtask

	// long sink hold while samples keep coming, pipeline fills and backs up
	task automatic test_sink_hold_off();
		source_gap_max = 0;
		sink_stall_max = 2;
		sink_hold_cycles = 300;
		send_random_samples(120);
		wait_for_results();
	endtask

	// bursts separated by full drains of the pipeline
	task automatic test_sender_pause();
		source_gap_max = 4;
		sink_stall_max = 4;
		repeat (10) begin
			send_random_samples($urandom_range(1, 30));
			wait_for_results();
		end
	endtask

	// mixed idling, alternating between quiet and busy sides
	task automatic test_mixed_idle_stream();
		source_gap_max = 0;
		sink_stall_max = 18;
		send_random_samples(250);
		source_gap_max = 18;
		sink_stall_max = 0;
		send_random_samples(250);
		wait_for_results();
	endtask

	// ---------------------------------------------------------------
	// result checker and sink ready driver
	// ---------------------------------------------------------------

	task automatic check_reading(input reading_t got);
		reading_t want;
		if (pending_readings.size() == 0) begin
			mismatch_count++;
			$display("%0t: result beat with nothing expected x=%0d y=%0d z=%0d heading=%0d",
				$time, got.x_value, got.y_value, got.z_value, got.heading);
			return;
		end
		want = pending_readings.pop_front();
		if (got.x_value !== want.x_value) begin
			mismatch_count++;
			$display("%0t: x_value expected %0d got %0d", $time, want.x_value, got.x_value);
		end
		if (got.y_value !== want.y_value) begin
			mismatch_count++;
			$display("%0t: y_value expected %0d got %0d", $time, want.y_value, got.y_value);
		end
		if (got.z_value !== want.z_value) begin
			mismatch_count++;
			$display("%0t: z_value expected %0d got %0d", $time, want.z_value, got.z_value);
		end
		if (got.heading !== want.heading) begin
			mismatch_count++;
			$display("%0t: heading_degrees expected %0d got %0d (x=%0d y=%0d)",
				$time, want.heading, got.heading, want.x_value, want.y_value);
		end
	endtask

	// samples every edge, checks a beat when valid and ready met, then picks
	// the next ready: long hold first, then the per-beat stall, else high
	initial begin
		int   stall_left;
		logic next_ready;
		reading_t got;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.x_value = result_ch.x_value;
				got.y_value = result_ch.y_value;
				got.z_value = result_ch.z_value;
				got.heading = result_ch.heading_degrees;
				check_reading(got);
				stall_left = $urandom_range(0, sink_stall_max);
			end
			if (sink_hold_cycles > 0) begin
				sink_hold_cycles--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			result_ch.ready <= next_ready;
		end
	end

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		mismatch_count   = 0;
		source_gap_max   = 0;
		sink_stall_max   = 0;
		sink_hold_cycles = 0;
		arst_n <= 1'b0;
		sample_ch.valid       <= 1'b0;
		sample_ch.x_high_byte <= '0;
		sample_ch.x_low_byte  <= '0;
		sample_ch.z_high_byte <= '0;
		sample_ch.z_low_byte  <= '0;
		sample_ch.y_high_byte <= '0;
		sample_ch.y_low_byte  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_headings();
		test_back_to_back_stream();
		test_random_idle_stream();
		test_sink_hold_off();
		test_sender_pause();
		test_mixed_idle_stream();

		// all results are in; give the pipeline time to show any stray beat
		wait_for_results();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(TIMEOUT_NS);
		$display("%0t: timeout with %0d readings outstanding", $time, pending_readings.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule
